/* rtl/core/fkw_pkg.sv */
package fkw_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_CALC,
    ST_DONE
  } fkw_state_t;

  localparam logic [2:0] REG_INV_A = 3'd0;
  localparam logic [2:0] REG_INV_B = 3'd1;
  localparam logic [2:0] REG_INV_C = 3'd2;
  localparam logic [2:0] REG_STEP_H = 3'd3;
  localparam logic [2:0] REG_STEP_INC = 3'd4;
  localparam logic [2:0] REG_RNG_SEED = 3'd5;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [30:0] LEHMER_M = 31'h7FFF_FFFF;
  localparam logic [14:0] LEHMER_A = 15'd16807;
  localparam logic [30:0] MOVE_LIMIT = 31'd715827883;
  localparam logic [30:0] DIR_LIMIT = 31'd1073741824;

  localparam logic [4:0] LAST_OP = 5'd31;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat33(s);
  endfunction

endpackage

/* rtl/core/fkw_in_if.sv */
interface fkw_in_if;
  logic valid;
  logic ready;
  logic func;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;

  modport source(output valid, func, start_x, start_y, start_z, input ready);
  modport sink(input valid, func, start_x, start_y, start_z, output ready);
endinterface

/* rtl/core/fkw_out_if.sv */
interface fkw_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] weight;
  logic exited;

  modport source(output valid, weight, exited, input ready);
  modport sink(input valid, weight, exited, output ready);
endinterface

/* rtl/core/fkw_mul.sv */
module fkw_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod_r;
  logic signed [63:0] shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
    end
  end

  assign shifted = prod_r >>> FRAC_BITS;

  always_comb begin
    if (shifted[63:31] == '0 || shifted[63:31] == '1) begin
      q = shifted[31:0];
    end else if (shifted[63]) begin
      q = 32'sh8000_0000;
    end else begin
      q = 32'sh7FFF_FFFF;
    end
  end

endmodule

/* rtl/core/fkw_rng.sv */
module fkw_rng
  import fkw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [30:0] seed,
  input  logic        step,
  output logic [30:0] draw
);

  logic [30:0] state_r;
  logic [45:0] prod;
  logic [31:0] folded;

  assign prod = 46'(state_r) * 46'(LEHMER_A);
  assign folded = 32'(prod[30:0]) + 32'(prod[45:31]);
  assign draw = (folded >= 32'(LEHMER_M)) ? 31'(folded - 32'(LEHMER_M)) : folded[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 31'd331;
    end else if (load) begin
      state_r <= seed;
    end else if (step) begin
      state_r <= draw;
    end
  end

endmodule

/* rtl/core/feynman_kac_walk_step.sv */
// One Feynman-Kac walker on an ellipsoid in signed fixed point with FRAC_BITS fraction
// bits. A start transfer (func 0) loads a point and weight 1.0 and goes straight to the
// done state; a step with no active path also goes straight to the done state. An
// advance first runs the Lehmer generator one draw per cycle, one or two draws per axis,
// then runs 32 operations, each a multiply phase and a writeback phase, on one shared
// registered multiplier. The result sits in an output register, and the next item is
// taken while it waits. Writing rng_seed reloads the generator state.
module feynman_kac_walk_step
  import fkw_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  fkw_in_if.sink      in_ch,
  fkw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [30:0] inv_a_r, inv_b_r, inv_c_r, step_h_r, step_inc_r, seed_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r, weight_r;
  logic signed [31:0] dx_r, dy_r, dz_r;
  logic signed [31:0] a4_r, b4_r, c4_r, sqx_r, sqy_r, sqz_r;
  logic signed [31:0] acc_r, vs_r, vh_r, tmp_r;
  logic active_r;
  fkw_state_t state_r, state_nxt;
  logic [4:0] op_r;
  logic phase_r;
  logic [1:0] axis_r;
  logic second_r;
  logic out_valid_r;
  logic signed [31:0] out_weight_r;
  logic out_exited_r;

  logic cfg_wr, seed_wr;
  logic [2:0] reg_idx;
  logic signed [31:0] ia, ib, ic, mul_a, mul_b, mul_q, acc_add, acc_new;
  logic [30:0] draw;
  logic rng_step;
  logic signed [31:0] dmove;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite;
  assign seed_wr = cfg_wr && reg_idx == REG_RNG_SEED;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_a_r <= 31'd1864135;
      inv_b_r <= 31'd4194304;
      inv_c_r <= 31'd16777216;
      step_h_r <= 31'd16777;
      step_inc_r <= 31'd918926;
      seed_r <= 31'd331;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_A: inv_a_r <= pwdata[30:0];
        REG_INV_B: inv_b_r <= pwdata[30:0];
        REG_INV_C: inv_c_r <= pwdata[30:0];
        REG_STEP_H: step_h_r <= pwdata[30:0];
        REG_STEP_INC: step_inc_r <= pwdata[30:0];
        REG_RNG_SEED: seed_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_A: prdata = {1'b0, inv_a_r};
      REG_INV_B: prdata = {1'b0, inv_b_r};
      REG_INV_C: prdata = {1'b0, inv_c_r};
      REG_STEP_H: prdata = {1'b0, step_h_r};
      REG_STEP_INC: prdata = {1'b0, step_inc_r};
      REG_RNG_SEED: prdata = {1'b0, seed_r};
      default: prdata = '0;
    endcase
  end

  assign ia = {1'b0, inv_a_r};
  assign ib = {1'b0, inv_b_r};
  assign ic = {1'b0, inv_c_r};

  assign rng_step = state_r == ST_DRAW;

  fkw_rng u_rng (
    .clk  (clk),
    .rst_n(rst_n),
    .load (seed_wr),
    .seed (pwdata[30:0]),
    .step (rng_step),
    .draw (draw)
  );

  fkw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk),
    .en (state_r == ST_CALC && !phase_r),
    .a  (mul_a),
    .b  (mul_b),
    .q  (mul_q)
  );

  always_comb begin
    case (op_r)
      5'd0: begin mul_a = ia; mul_b = ia; end
      5'd1: begin mul_a = ib; mul_b = ib; end
      5'd2: begin mul_a = ic; mul_b = ic; end
      5'd3, 5'd14: begin mul_a = pos_x_r; mul_b = pos_x_r; end
      5'd4, 5'd15: begin mul_a = sqx_r; mul_b = a4_r; end
      5'd5, 5'd16: begin mul_a = pos_y_r; mul_b = pos_y_r; end
      5'd6, 5'd17: begin mul_a = sqy_r; mul_b = b4_r; end
      5'd7, 5'd18: begin mul_a = pos_z_r; mul_b = pos_z_r; end
      5'd8, 5'd19: begin mul_a = sqz_r; mul_b = c4_r; end
      5'd24: begin mul_a = {1'b0, step_h_r}; mul_b = vs_r; end
      5'd25: begin mul_a = qsub(ONE, tmp_r); mul_b = weight_r; end
      5'd26: begin mul_a = vh_r; mul_b = tmp_r; end
      5'd27: begin mul_a = vs_r; mul_b = weight_r; end
      5'd28: begin mul_a = {2'b00, step_h_r[30:1]}; mul_b = acc_r; end
      5'd29: begin mul_a = sqx_r; mul_b = ia; end
      5'd30: begin mul_a = sqy_r; mul_b = ib; end
      5'd31: begin mul_a = sqz_r; mul_b = ic; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign acc_add = qadd(acc_r, mul_q);
  assign acc_new = acc_add;
  assign dmove = (draw < DIR_LIMIT) ? -$signed({1'b0, step_inc_r})
                                    : $signed({1'b0, step_inc_r});

  assign in_ch.ready = state_r == ST_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.weight = out_weight_r;
  assign out_ch.exited = out_exited_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_STEP && active_r) begin
            state_nxt = ST_DRAW;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DRAW: begin
        if (axis_r == 2'd2 && (second_r || draw >= MOVE_LIMIT)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (phase_r && op_r == LAST_OP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      weight_r <= '0;
      active_r <= 1'b0;
      op_r <= '0;
      phase_r <= 1'b0;
      axis_r <= '0;
      second_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          op_r <= '0;
          phase_r <= 1'b0;
          axis_r <= '0;
          second_r <= 1'b0;
          if (in_ch.valid && in_ch.func == FUNC_START) begin
            pos_x_r <= in_ch.start_x;
            pos_y_r <= in_ch.start_y;
            pos_z_r <= in_ch.start_z;
            weight_r <= ONE;
            active_r <= 1'b1;
          end
        end
        ST_DRAW: begin
          if (!second_r && draw < MOVE_LIMIT) begin
            second_r <= 1'b1;
          end else begin
            second_r <= 1'b0;
            axis_r <= axis_r + 2'd1;
            case (axis_r)
              2'd0: dx_r <= second_r ? dmove : '0;
              2'd1: dy_r <= second_r ? dmove : '0;
              default: dz_r <= second_r ? dmove : '0;
            endcase
          end
        end
        ST_CALC: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            op_r <= op_r + 5'd1;
            case (op_r)
              5'd0: a4_r <= mul_q;
              5'd1: b4_r <= mul_q;
              5'd2: c4_r <= mul_q;
              5'd3, 5'd14: sqx_r <= mul_q;
              5'd4, 5'd15, 5'd26, 5'd29: acc_r <= mul_q;
              5'd5, 5'd16: sqy_r <= mul_q;
              5'd7, 5'd18: sqz_r <= mul_q;
              5'd6, 5'd8, 5'd17, 5'd19, 5'd27, 5'd30: acc_r <= acc_add;
              5'd9, 5'd20: acc_r <= qadd(acc_r, acc_r);
              5'd10, 5'd21: acc_r <= qadd(acc_r, ia);
              5'd11, 5'd22: acc_r <= qadd(acc_r, ib);
              5'd12: vs_r <= qadd(acc_r, ic);
              5'd13: begin
                pos_x_r <= qadd(pos_x_r, dx_r);
                pos_y_r <= qadd(pos_y_r, dy_r);
                pos_z_r <= qadd(pos_z_r, dz_r);
              end
              5'd23: vh_r <= qadd(acc_r, ic);
              5'd24, 5'd25: tmp_r <= mul_q;
              5'd28: weight_r <= qsub(weight_r, mul_q);
              5'd31: begin
                if (acc_new >= ONE) begin
                  active_r <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_weight_r <= weight_r;
            out_exited_r <= !active_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* verif/tb_feynman_kac_walk_step.sv */
`timescale 1ns / 100ps

module tb_feynman_kac_walk_step;
  import fkw_pkg::*;

  localparam int FRAC = 24;
  localparam longint ONE_Q = longint'(1) <<< FRAC;
  localparam longint REG_MASK = 64'h7FFF_FFFF;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int N_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    int weight;
    bit exited;
  } walk_result_t;

  class walk_scoreboard;
    longint inv_a, inv_b, inv_c, step_h, step_inc, rng;
    int px, py, pz, pw;
    bit active;
    walk_result_t pending_q[$];
    int fails;
    int checked;

    function new();
      inv_a = 1864135;
      inv_b = 4194304;
      inv_c = 16777216;
      step_h = 16777;
      step_inc = 918926;
      rng = 331;
      px = 0;
      py = 0;
      pz = 0;
      pw = 0;
      active = 0;
      fails = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, longint val);
      longint v;
      v = val & REG_MASK;
      case (idx)
        REG_INV_A: inv_a = v;
        REG_INV_B: inv_b = v;
        REG_INV_C: inv_c = v;
        REG_STEP_H: step_h = v;
        REG_STEP_INC: step_inc = v;
        REG_RNG_SEED: rng = v;
        default: ;
      endcase
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function int qm(int a, int b);
      return sat((longint'(a) * longint'(b)) >>> FRAC);
    endfunction

    function int qa(int a, int b);
      return sat(longint'(a) + longint'(b));
    endfunction

    function longint draw();
      rng = (rng * 16807) % 2147483647;
      return rng - 1;
    endfunction

    function int axis_move();
      longint u, w;
      u = draw();
      if (3 * u < 2147483646) begin
        w = draw();
        return (w < 1073741823) ? sat(-step_inc) : int'(step_inc);
      end
      return 0;
    endfunction

    function int potential(int x, int y, int z);
      int a4, b4, c4, s;
      a4 = qm(int'(inv_a), int'(inv_a));
      b4 = qm(int'(inv_b), int'(inv_b));
      c4 = qm(int'(inv_c), int'(inv_c));
      s = qa(qa(qm(qm(x, x), a4), qm(qm(y, y), b4)), qm(qm(z, z), c4));
      s = qa(s, s);
      s = qa(s, int'(inv_a));
      s = qa(s, int'(inv_b));
      return qa(s, int'(inv_c));
    endfunction

    function void note_input(logic fn, int x, int y, int z);
      int dx, dy, dz, vs, vh, ye, t, chk;
      walk_result_t r;
      if (fn == FUNC_START) begin
        px = x;
        py = y;
        pz = z;
        pw = int'(ONE_Q);
        active = 1;
      end else if (active) begin
        dx = axis_move();
        dy = axis_move();
        dz = axis_move();
        vs = potential(px, py, pz);
        px = qa(px, dx);
        py = qa(py, dy);
        pz = qa(pz, dz);
        vh = potential(px, py, pz);
        ye = qm(sat(ONE_Q - longint'(qm(int'(step_h), vs))), pw);
        t = qm(int'(step_h >> 1), qa(qm(vh, ye), qm(vs, pw)));
        pw = sat(longint'(pw) - longint'(t));
        chk = qa(qa(qm(qm(px, px), int'(inv_a)), qm(qm(py, py), int'(inv_b))),
                 qm(qm(pz, pz), int'(inv_c)));
        if (longint'(chk) >= ONE_Q) active = 0;
      end
      r.weight = pw;
      r.exited = !active;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] weight, logic exited);
      walk_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: weight %0d exited %0b", weight, exited);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (weight !== e.weight) begin
        $error("weight mismatch: expected %0d actual %0d", e.weight, weight);
        fails++;
      end
      if (exited !== e.exited) begin
        $error("exited mismatch: expected %0b actual %0b", e.exited, exited);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fkw_in_if in_ch();
  fkw_out_if out_ch();

  feynman_kac_walk_step i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  walk_scoreboard walk_sb;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cfg_writes;
  int cfg_fails;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) walk_sb.check_result(out_ch.weight, out_ch.exited);
  end

  task automatic send_walk(logic fn, int x, int y, int z);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.start_x <= x;
    in_ch.start_y <= y;
    in_ch.start_z <= z;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    walk_sb.note_input(fn, x, y, z);
    items_sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (walk_sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    walk_sb.write_reg(idx, longint'(val));
    cfg_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx <= REG_RNG_SEED) begin
      penable <= 1'b1;
      @(posedge clk);
      if (prdata !== (val & 32'h7FFF_FFFF)) begin
        $error("register %0d readback: expected %0h actual %0h", idx, val & 32'h7FFF_FFFF,
               prdata);
        cfg_fails++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h0100_0000, 32'h0040_0000);
      3: return $urandom;
      default: return $urandom_range(32'h0200_0000, 32'h0001_0000);
    endcase
  endfunction

  task automatic random_config();
    cfg_write(REG_INV_A, pick_inv());
    cfg_write(REG_INV_B, pick_inv());
    cfg_write(REG_INV_C, pick_inv());
    case ($urandom_range(3))
      0: cfg_write(REG_STEP_H, 32'd0);
      1: cfg_write(REG_STEP_H, 32'h7FFF_FFFF);
      2: cfg_write(REG_STEP_H, $urandom);
      default: cfg_write(REG_STEP_H, $urandom_range(32'h0010_0000, 1));
    endcase
    case ($urandom_range(3))
      0: cfg_write(REG_STEP_INC, 32'd0);
      1: cfg_write(REG_STEP_INC, 32'h7FFF_FFFF);
      2: cfg_write(REG_STEP_INC, $urandom);
      default: cfg_write(REG_STEP_INC, $urandom_range(32'h0080_0000, 1));
    endcase
    cfg_write(REG_RNG_SEED, {1'($urandom), 31'($urandom_range(32'h7FFF_FFFE, 1))});
  endtask

  function automatic int near_unit();
    return int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  initial begin
    int n_steps;
    walk_sb = new();
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cfg_writes = 0;
    cfg_fails = 0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_START;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.start_z <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: idle path, extreme points, degenerate seeds, extreme registers.
    send_walk(FUNC_STEP, 0, 0, 0);
    send_walk(FUNC_START, 0, 0, 0);
    repeat (3) send_walk(FUNC_STEP, 0, 0, 0);
    send_walk(FUNC_START, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_walk(FUNC_STEP, 0, 0, 0);
    send_walk(FUNC_STEP, -1, -1, -1);
    send_walk(FUNC_START, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_walk(FUNC_STEP, 0, 0, 0);
    drain();
    cfg_write(REG_RNG_SEED, 32'd0);
    cfg_write(REG_SPARE_LO, 32'h1234_5678);
    cfg_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    send_walk(FUNC_START, 0, 0, 0);
    repeat (2) send_walk(FUNC_STEP, 0, 0, 0);
    drain();
    cfg_write(REG_RNG_SEED, 32'hFFFF_FFFF);
    send_walk(FUNC_START, 32'sh0080_0000, 0, 0);
    send_walk(FUNC_STEP, 0, 0, 0);
    drain();
    cfg_write(REG_INV_A, 32'hFFFF_FFFF);
    cfg_write(REG_INV_B, 32'h7FFF_FFFF);
    cfg_write(REG_INV_C, 32'h7FFF_FFFF);
    cfg_write(REG_STEP_H, 32'h7FFF_FFFF);
    cfg_write(REG_STEP_INC, 32'h7FFF_FFFF);
    cfg_write(REG_RNG_SEED, 32'h7FFF_FFFE);
    send_walk(FUNC_START, 32'sh0000_1000, -32'sh0000_1000, 0);
    repeat (2) send_walk(FUNC_STEP, 0, 0, 0);
    drain();
    cfg_write(REG_INV_A, 32'd0);
    cfg_write(REG_INV_B, 32'd0);
    cfg_write(REG_INV_C, 32'd0);
    cfg_write(REG_STEP_H, 32'd0);
    cfg_write(REG_STEP_INC, 32'd0);
    cfg_write(REG_RNG_SEED, 32'd1);
    send_walk(FUNC_START, 32'sh4000_0000, 0, 0);
    send_walk(FUNC_STEP, 0, 0, 0);
    drain();
    cfg_write(REG_INV_A, 32'd1864135);
    cfg_write(REG_INV_B, 32'd4194304);
    cfg_write(REG_INV_C, 32'd16777216);
    cfg_write(REG_STEP_H, 32'd16777);
    cfg_write(REG_STEP_INC, 32'd918926);
    cfg_write(REG_RNG_SEED, 32'd331);

    for (int blk = 0; items_sent < N_ITEMS; blk++) begin
      case (blk % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 62; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 62; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (blk % 6 == 5) begin
        drain();
        if ($urandom_range(1)) random_config();
        else begin
          cfg_write(REG_INV_A, 32'd1864135);
          cfg_write(REG_INV_B, 32'd4194304);
          cfg_write(REG_INV_C, 32'd16777216);
          cfg_write(REG_STEP_H, 32'd16777);
          cfg_write(REG_STEP_INC, 32'd918926);
        end
      end
      if ($urandom_range(99) < 80) begin
        send_walk(FUNC_START, near_unit(), near_unit(), near_unit());
        n_steps = $urandom_range(40, 1);
        repeat (n_steps) send_walk(FUNC_STEP, $urandom, $urandom, $urandom);
      end else begin
        repeat ($urandom_range(6, 1))
          send_walk(1'($urandom), $urandom, $urandom, $urandom);
      end
    end

    drain();
    $display("Covered %0d walker transfers and %0d checked results under %0d register writes,",
             items_sent, walk_sb.checked, cfg_writes);
    $display("with sender gaps, receiver stalls and both together.");
    if (walk_sb.fails == 0 && cfg_fails == 0 && walk_sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fkw_pkg.sv
rtl/core/fkw_in_if.sv
rtl/core/fkw_out_if.sv
rtl/core/fkw_mul.sv
rtl/core/fkw_rng.sv
rtl/core/feynman_kac_walk_step.sv
verif/tb_feynman_kac_walk_step.sv
